// ===== rtl/osa_pkg.sv =====
// osa_pkg: sizes and types for the OSA edit distance block.
// No dependencies; used by osa_edit_distance_top.
package osa_pkg;

  localparam int MAX_LEN     = 64;
  localparam int SYMBOL_BITS = 8;
  localparam int ROW_DEPTH   = MAX_LEN + 1;
  localparam int LEN_W       = $clog2(MAX_LEN + 1);
  localparam int IDX_W       = $clog2(MAX_LEN);
  localparam int SYM_W       = SYMBOL_BITS;
  localparam int DIST_W      = 7;
  localparam int DIST_MAX    = (2 ** DIST_W) - 1;

  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [LEN_W:0]    ext_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SYM_W-1:0]  sym_t;
  typedef logic [DIST_W-1:0] dist_t;

endpackage

// ===== rtl/osa_edit_distance_top.sv =====
// A first-string request is taken in ST_IDLE. A second-string byte sweeps the stored row
// one cell per cycle through one shared cell-update unit, over cells 0 to n, n = first string
// length. A request that closes the pair passes through ST_EMIT to load the result
// register, and waits there while the previous result is held by out_stall.
// An ignored or empty-string request needs no row sweep.
// Reset: synchronous, active high; clears control state only. Row and character stores are
// not cleared; the initial row is generated from the cell index, so no clearing pass is run.
// osa_edit_distance_top: restricted Damerau-Levenshtein distance, iterative row update.
// Depends on osa_pkg.
module osa_edit_distance_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 kind,
  input  logic [7:0]           symbol,
  input  logic                 empty_req,
  input  logic                 last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output osa_pkg::dist_t       distance,
  output logic                 overflow
);

  typedef enum logic [1:0] {ST_IDLE, ST_ROW, ST_EMIT} state_t;

  function automatic osa_pkg::dist_t sat_dist(osa_pkg::len_t v);
    if (int'(v) > osa_pkg::DIST_MAX) begin
      return osa_pkg::dist_t'(osa_pkg::DIST_MAX);
    end
    return osa_pkg::dist_t'(v);
  endfunction

  // stores
  osa_pkg::sym_t fc_mem [osa_pkg::MAX_LEN];
  osa_pkg::len_t rp_mem [osa_pkg::ROW_DEPTH];
  osa_pkg::len_t ro_mem [osa_pkg::ROW_DEPTH];

  // pair state
  state_t         state;
  osa_pkg::len_t  first_length;
  logic           first_closed;
  osa_pkg::len_t  second_count;
  osa_pkg::sym_t  prior_sym;
  logic           overflow_seen;
  osa_pkg::len_t  last_dist;

  // row sweep
  osa_pkg::sym_t  cur_sym;
  logic           cur_fin;
  osa_pkg::len_t  rd_addr;
  logic           q_live;
  osa_pkg::len_t  q_idx;
  osa_pkg::len_t  rp_q;
  osa_pkg::len_t  ro_q;
  osa_pkg::sym_t  fc_q;
  osa_pkg::len_t  diag;
  osa_pkg::len_t  diag2;
  osa_pkg::sym_t  fc_prev;
  osa_pkg::len_t  left;

  osa_pkg::dist_t res_dist;
  logic           res_ovf;

  logic           in_take;
  logic           out_free;
  osa_pkg::sym_t  sym_in;
  osa_pkg::len_t  len_eff;
  logic           fc_wr;
  osa_pkg::idx_t  fc_wr_addr;
  logic           issue;
  osa_pkg::len_t  rd_m1;
  osa_pkg::idx_t  fc_addr;
  osa_pkg::len_t  ro_addr;
  osa_pkg::len_t  rp_val;
  logic           cost;
  osa_pkg::ext_t  c_up;
  osa_pkg::ext_t  c_left;
  osa_pkg::ext_t  c_diag;
  osa_pkg::ext_t  c_tr;
  osa_pkg::ext_t  m1;
  osa_pkg::ext_t  m2;
  osa_pkg::ext_t  m3;
  logic           trans_ok;
  osa_pkg::len_t  fresh;
  logic           cell_done;
  osa_pkg::len_t  held_dist;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign sym_in   = osa_pkg::sym_t'(symbol);

  assign len_eff    = first_closed ? '0 : first_length;
  assign fc_wr      = in_take && !kind && !empty_req &&
                      (len_eff < osa_pkg::len_t'(osa_pkg::MAX_LEN));
  assign fc_wr_addr = len_eff[osa_pkg::IDX_W-1:0];
  assign held_dist  = (second_count == '0) ? first_length : last_dist;

  assign issue   = (state == ST_ROW) && (rd_addr <= first_length);
  assign rd_m1   = rd_addr - osa_pkg::len_t'(1);
  assign fc_addr = (rd_addr == '0) ? '0 : rd_m1[osa_pkg::IDX_W-1:0];
  assign ro_addr = (rd_addr >= osa_pkg::len_t'(2)) ? (rd_addr - osa_pkg::len_t'(2)) : '0;

  // shared cell update; row 0 is implied by the index before the first second byte
  always_comb begin
    rp_val   = (second_count == '0) ? q_idx : rp_q;
    cost     = (fc_q != cur_sym);
    c_up     = {1'b0, rp_val} + osa_pkg::ext_t'(1);
    c_left   = {1'b0, left} + osa_pkg::ext_t'(1);
    c_diag   = {1'b0, diag} + osa_pkg::ext_t'(cost);
    c_tr     = {1'b0, ro_q} + osa_pkg::ext_t'(1);
    m1       = (c_up <= c_left) ? c_up : c_left;
    m2       = (m1 <= c_diag) ? m1 : c_diag;
    trans_ok = (q_idx > osa_pkg::len_t'(1)) && (second_count != '0) &&
               (fc_q == prior_sym) && (fc_prev == cur_sym);
    m3       = (trans_ok && (c_tr < m2)) ? c_tr : m2;
    fresh    = (q_idx == '0) ? (second_count + osa_pkg::len_t'(1))
                             : osa_pkg::len_t'(m3);
  end

  assign cell_done = q_live && (q_idx == first_length);

  always_ff @(posedge clk) begin
    if (fc_wr) begin
      fc_mem[fc_wr_addr] <= sym_in;
    end
    if (issue) begin
      rp_q <= rp_mem[rd_addr];
      fc_q <= fc_mem[fc_addr];
      ro_q <= ro_mem[ro_addr];
    end
    if (q_live) begin
      rp_mem[q_idx] <= fresh;
    end
    if (q_live && (q_idx >= osa_pkg::len_t'(2))) begin
      ro_mem[q_idx - osa_pkg::len_t'(2)] <= diag2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      first_length  <= '0;
      first_closed  <= 1'b0;
      second_count  <= '0;
      prior_sym     <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
      q_live        <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (!kind) begin
              second_count <= '0;
              if (first_closed) begin
                prior_sym <= '0;
              end
              if (empty_req) begin
                first_length  <= len_eff;
                overflow_seen <= first_closed ? 1'b0 : overflow_seen;
                first_closed  <= 1'b1;
              end else begin
                if (len_eff < osa_pkg::len_t'(osa_pkg::MAX_LEN)) begin
                  first_length  <= len_eff + osa_pkg::len_t'(1);
                  overflow_seen <= first_closed ? 1'b0 : overflow_seen;
                end else begin
                  first_length  <= len_eff;
                  overflow_seen <= 1'b1;
                end
                first_closed <= last;
              end
            end else if (first_closed) begin
              if (empty_req) begin
                res_dist      <= sat_dist(held_dist);
                res_ovf       <= overflow_seen;
                first_length  <= '0;
                first_closed  <= 1'b0;
                second_count  <= '0;
                prior_sym     <= '0;
                overflow_seen <= 1'b0;
                state         <= ST_EMIT;
              end else if (second_count < osa_pkg::len_t'(osa_pkg::MAX_LEN)) begin
                cur_sym <= sym_in;
                cur_fin <= last;
                rd_addr <= '0;
                q_live  <= 1'b0;
                state   <= ST_ROW;
              end else begin
                if (last) begin
                  res_dist      <= sat_dist(held_dist);
                  res_ovf       <= 1'b1;
                  first_length  <= '0;
                  first_closed  <= 1'b0;
                  second_count  <= '0;
                  prior_sym     <= '0;
                  overflow_seen <= 1'b0;
                  state         <= ST_EMIT;
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
            end
          end
        end
        ST_ROW: begin
          if (issue) begin
            rd_addr <= rd_addr + osa_pkg::len_t'(1);
          end
          q_live <= issue;
          q_idx  <= rd_addr;
          if (q_live) begin
            left    <= fresh;
            diag    <= rp_val;
            diag2   <= diag;
            fc_prev <= fc_q;
          end
          if (cell_done) begin
            last_dist <= fresh;
            if (cur_fin) begin
              res_dist      <= sat_dist(fresh);
              res_ovf       <= overflow_seen;
              first_length  <= '0;
              first_closed  <= 1'b0;
              second_count  <= '0;
              prior_sym     <= '0;
              overflow_seen <= 1'b0;
              state         <= ST_EMIT;
            end else begin
              prior_sym    <= cur_sym;
              second_count <= second_count + osa_pkg::len_t'(1);
              state        <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            distance  <= res_dist;
            overflow  <= res_ovf;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (first_length <= osa_pkg::len_t'(osa_pkg::MAX_LEN)) &&
    (second_count <= osa_pkg::len_t'(osa_pkg::MAX_LEN)))
    else $error("pair length beyond store size");

  a_cell_range: assert property (@(posedge clk) disable iff (rst)
    q_live |-> (q_idx <= first_length) && (state == ST_ROW))
    else $error("row cell index out of range");

  a_row_needs_first: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROW) |-> first_closed)
    else $error("row update without closed first string");

  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (distance <= sat_dist(osa_pkg::len_t'(osa_pkg::MAX_LEN))))
    else $error("distance beyond store size");
`endif

endmodule
